// ----- hdl/tw_odo_pkg.sv -----
// Shared types, constants and helper functions for the tracking wheel odometry block.
// Used by the rotator, the multiplier/divider and the top level; depends on nothing else.
package tw_odo_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_DEPTH       = 24;

    localparam int CFG_W  = 23;
    localparam int DEN_W  = 33;
    localparam int LEN_W  = 34;
    localparam int VEC_W  = 36;

    localparam longint Q30_TWO_PI  = 64'sd6746518852;
    localparam longint Q30_PI      = 64'sd3373259426;
    localparam longint Q30_HALF_PI = 64'sd1686629713;
    localparam longint Q30_ONE     = 64'sd1073741824;

    localparam logic [29:0] Q30_GAIN    = 30'd652032874;
    localparam logic [29:0] Q24_RAD2DEG = 30'd961263670;

    typedef enum logic [1:0] {
        FUNC_UPDATE = 2'd0,
        FUNC_START  = 2'd1,
        FUNC_SET    = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REG_TRACKER_MODE = 2'd0,
        REG_FWD_OFFSET   = 2'd1,
        REG_SIDE_OFFSET  = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_MOTORS     = 2'd0,
        MODE_FORWARD    = 2'd1,
        MODE_SIDE_RIGHT = 2'd2,
        MODE_TWO        = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_ROT1,
        ST_DIVS,
        ST_MULS,
        ST_DIVF,
        ST_MULF,
        ST_ROT2,
        ST_DEG,
        ST_OUT
    } seq_state_t;

    typedef enum logic [3:0] {
        ROT_IDLE,
        ROT_REDUCE,
        ROT_SIGN,
        ROT_WRAP,
        ROT_FOLD,
        ROT_GAIN_X,
        ROT_GAIN_Y,
        ROT_ITER,
        ROT_DONE
    } rot_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_RUN,
        MD_DONE
    } md_state_t;

    typedef enum logic {
        MD_OP_DIV = 1'b0,
        MD_OP_MUL = 1'b1
    } md_op_t;

    typedef struct packed {
        logic   start;
        md_op_t op;
    } md_req_t;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837830;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048576;
            5'd11:   v = 30'd524288;
            5'd12:   v = 30'd262144;
            5'd13:   v = 30'd131072;
            5'd14:   v = 30'd65536;
            5'd15:   v = 30'd32768;
            5'd16:   v = 30'd16384;
            5'd17:   v = 30'd8192;
            5'd18:   v = 30'd4096;
            5'd19:   v = 30'd2048;
            5'd20:   v = 30'd1024;
            5'd21:   v = 30'd512;
            5'd22:   v = 30'd256;
            5'd23:   v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/tw_odo_rotator.sv -----
// Iterative CORDIC rotator: angle reduction modulo 2*pi, quadrant fold, gain, rotation steps.
// Depends on tw_odo_pkg.
module tw_odo_rotator #(
    parameter int ANG_W        = 48,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic signed [32:0]                    x_in,
    input  logic signed [32:0]                    y_in,
    input  logic signed [ANG_W-1:0]               angle_in,
    output logic                                  done,
    output logic signed [tw_odo_pkg::VEC_W-1:0]   x_out,
    output logic signed [tw_odo_pkg::VEC_W-1:0]   y_out
);

    localparam int R_W       = tw_odo_pkg::VEC_W;
    localparam int RED_STEPS = ANG_W - 33;
    localparam int KW        = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
    localparam int ITER_N    = (CORDIC_STEPS < tw_odo_pkg::ATAN_DEPTH) ?
                               CORDIC_STEPS : tw_odo_pkg::ATAN_DEPTH;

    localparam logic signed [R_W-1:0] TWO_PI_R  = R_W'(tw_odo_pkg::Q30_TWO_PI);
    localparam logic signed [R_W-1:0] PI_R      = R_W'(tw_odo_pkg::Q30_PI);
    localparam logic signed [R_W-1:0] HALF_PI_R = R_W'(tw_odo_pkg::Q30_HALF_PI);

    tw_odo_pkg::rot_state_t state_reg, state_next;
    logic [KW-1:0]          k_reg, k_next;
    logic [4:0]             i_reg, i_next;
    logic                   neg_reg, neg_next;
    logic [ANG_W-1:0]       mag_reg, mag_next;
    logic signed [R_W-1:0]  r_reg, r_next;
    logic signed [R_W-1:0]  cx_reg, cx_next;
    logic signed [R_W-1:0]  cy_reg, cy_next;

    logic [ANG_W-1:0]       sub_val;
    logic signed [32:0]     mul_a;
    logic signed [63:0]     gprod;
    logic signed [R_W-1:0]  dx;
    logic signed [R_W-1:0]  dy;
    logic signed [R_W-1:0]  at;

    assign sub_val = ANG_W'(tw_odo_pkg::Q30_TWO_PI) << k_reg;
    assign mul_a   = (state_reg == tw_odo_pkg::ROT_GAIN_Y) ? cy_reg[32:0] : cx_reg[32:0];
    assign gprod   = mul_a * $signed({1'b0, tw_odo_pkg::Q30_GAIN});
    assign dx      = cy_reg >>> i_reg;
    assign dy      = cx_reg >>> i_reg;
    assign at      = $signed({{(R_W-30){1'b0}}, tw_odo_pkg::atan_q30(i_reg)});

    assign done  = (state_reg == tw_odo_pkg::ROT_DONE);
    assign x_out = cx_reg;
    assign y_out = cy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tw_odo_pkg::ROT_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg   <= k_next;
        i_reg   <= i_next;
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        r_reg   <= r_next;
        cx_reg  <= cx_next;
        cy_reg  <= cy_next;
    end

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        r_next     = r_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        case (state_reg)
            tw_odo_pkg::ROT_IDLE: begin
                if (start) begin
                    cx_next    = R_W'(x_in);
                    cy_next    = R_W'(y_in);
                    neg_next   = angle_in[ANG_W-1];
                    mag_next   = angle_in[ANG_W-1] ? ANG_W'(-angle_in) : ANG_W'(angle_in);
                    k_next     = KW'(RED_STEPS - 1);
                    state_next = tw_odo_pkg::ROT_REDUCE;
                end
            end
            tw_odo_pkg::ROT_REDUCE: begin
                if (mag_reg >= sub_val) begin
                    mag_next = mag_reg - sub_val;
                end
                k_next = k_reg - KW'(1);
                if (k_reg == '0) begin
                    state_next = tw_odo_pkg::ROT_SIGN;
                end
            end
            tw_odo_pkg::ROT_SIGN: begin
                r_next     = neg_reg ? -$signed(R_W'(mag_reg)) : $signed(R_W'(mag_reg));
                state_next = tw_odo_pkg::ROT_WRAP;
            end
            tw_odo_pkg::ROT_WRAP: begin
                if (r_reg > PI_R) begin
                    r_next = r_reg - TWO_PI_R;
                end else if (r_reg < -PI_R) begin
                    r_next = r_reg + TWO_PI_R;
                end
                state_next = tw_odo_pkg::ROT_FOLD;
            end
            tw_odo_pkg::ROT_FOLD: begin
                if (r_reg > HALF_PI_R) begin
                    cx_next = -cx_reg;
                    cy_next = -cy_reg;
                    r_next  = r_reg - PI_R;
                end else if (r_reg < -HALF_PI_R) begin
                    cx_next = -cx_reg;
                    cy_next = -cy_reg;
                    r_next  = r_reg + PI_R;
                end
                state_next = tw_odo_pkg::ROT_GAIN_X;
            end
            tw_odo_pkg::ROT_GAIN_X: begin
                cx_next    = R_W'(gprod >>> 30);
                state_next = tw_odo_pkg::ROT_GAIN_Y;
            end
            tw_odo_pkg::ROT_GAIN_Y: begin
                cy_next    = R_W'(gprod >>> 30);
                i_next     = '0;
                state_next = tw_odo_pkg::ROT_ITER;
            end
            tw_odo_pkg::ROT_ITER: begin
                if (r_reg >= 0) begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    r_next  = r_reg - at;
                end else begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    r_next  = r_reg + at;
                end
                i_next = i_reg + 5'd1;
                if (i_reg == 5'(ITER_N - 1)) begin
                    state_next = tw_odo_pkg::ROT_DONE;
                end
            end
            tw_odo_pkg::ROT_DONE: begin
                state_next = tw_odo_pkg::ROT_IDLE;
            end
            default: begin
                state_next = tw_odo_pkg::ROT_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/tw_odo_muldiv.sv -----
// Serial divider (truncating) and serial shift-add multiplier with Q30 saturating scaling.
// One shared register pair serves both; depends on tw_odo_pkg.
module tw_odo_muldiv #(
    parameter int NUM_W = 49
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  tw_odo_pkg::md_req_t                   req,
    input  logic signed [NUM_W-1:0]               num_in,
    input  logic signed [tw_odo_pkg::DEN_W-1:0]   den_in,
    input  logic signed [NUM_W:0]                 a_in,
    input  logic signed [tw_odo_pkg::LEN_W-1:0]   b_in,
    output logic                                  done,
    output logic signed [NUM_W-1:0]               quot_out,
    output logic signed [31:0]                    prod_out
);

    localparam int A_W  = NUM_W + 1;
    localparam int H    = A_W + 1;
    localparam int L    = NUM_W;
    localparam int B_W  = tw_odo_pkg::LEN_W;
    localparam int D_W  = tw_odo_pkg::DEN_W;
    localparam int P_W  = H + B_W;
    localparam int CW   = $clog2(NUM_W + 1);

    tw_odo_pkg::md_state_t state_reg, state_next;
    tw_odo_pkg::md_op_t    op_reg, op_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;
    logic [H-1:0]          hi_reg, hi_next;
    logic [L-1:0]          lo_reg, lo_next;
    logic [A_W-1:0]        opnd_reg, opnd_next;

    logic [H-1:0]          trial;
    logic                  ge;
    logic [H-1:0]          acc_sum;
    logic [P_W-1:0]        product;
    logic [P_W-31:0]       scaled;
    logic                  big;

    assign trial   = {hi_reg[H-2:0], lo_reg[L-1]};
    assign ge      = trial >= H'(opnd_reg);
    assign acc_sum = lo_reg[0] ? (hi_reg + H'(opnd_reg)) : hi_reg;
    assign product = {hi_reg, lo_reg[L-1:L-B_W]};
    assign scaled  = product[P_W-1:30];
    assign big     = |scaled[P_W-31:31];

    assign done     = (state_reg == tw_odo_pkg::MD_DONE);
    assign quot_out = neg_reg ? -$signed(lo_reg) : $signed(lo_reg);

    always_comb begin
        if (!neg_reg) begin
            prod_out = big ? 32'sh7fffffff : $signed(scaled[31:0]);
        end else if (big || scaled[31]) begin
            prod_out = 32'sh80000000;
        end else begin
            prod_out = -$signed(scaled[31:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tw_odo_pkg::MD_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        hi_reg   <= hi_next;
        lo_reg   <= lo_next;
        opnd_reg <= opnd_next;
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        opnd_next  = opnd_reg;
        case (state_reg)
            tw_odo_pkg::MD_IDLE: begin
                if (req.start) begin
                    op_next    = req.op;
                    hi_next    = '0;
                    state_next = tw_odo_pkg::MD_RUN;
                    if (req.op == tw_odo_pkg::MD_OP_DIV) begin
                        neg_next  = num_in[NUM_W-1] ^ den_in[D_W-1];
                        lo_next   = num_in[NUM_W-1] ? L'(-num_in) : L'(num_in);
                        opnd_next = den_in[D_W-1] ? A_W'(D_W'(-den_in)) : A_W'(D_W'(den_in));
                        cnt_next  = CW'(NUM_W - 1);
                    end else begin
                        neg_next  = a_in[A_W-1] ^ b_in[B_W-1];
                        lo_next   = b_in[B_W-1] ? L'(B_W'(-b_in)) : L'(B_W'(b_in));
                        opnd_next = a_in[A_W-1] ? A_W'(-a_in) : A_W'(a_in);
                        cnt_next  = CW'(B_W - 1);
                    end
                end
            end
            tw_odo_pkg::MD_RUN: begin
                if (op_reg == tw_odo_pkg::MD_OP_DIV) begin
                    hi_next = ge ? (trial - H'(opnd_reg)) : trial;
                    lo_next = {lo_reg[L-2:0], ge};
                end else begin
                    hi_next = acc_sum >> 1;
                    lo_next = {acc_sum[0], lo_reg[L-1:1]};
                end
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    state_next = tw_odo_pkg::MD_DONE;
                end
            end
            tw_odo_pkg::MD_DONE: begin
                state_next = tw_odo_pkg::MD_IDLE;
            end
            default: begin
                state_next = tw_odo_pkg::MD_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/tracking_wheel_odometry_update.sv -----
// Tracking wheel arc odometry: one pose update per update beat, one result beat per input beat.
// For an update sample the serial divider (one quotient bit a cycle), the serial multiplier
// (one bit of the chord length a cycle) and the CORDIC rotator (one reduction or rotation
// step a cycle) each run twice. An update with an unchanged heading skips the first rotation
// and the divide and multiply passes. The input is not ready while an item is in work; a
// finished result waits in the output register while the next item is already taken, and
// the last state holds for as long as that result stays unread.
// Depends on tw_odo_pkg, tw_odo_rotator and tw_odo_muldiv.
module tracking_wheel_odometry_update #(
    parameter int FRAC_BITS    = tw_odo_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = tw_odo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_addr,
    input  logic [tw_odo_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // forward_pos, sideways_pos, left_motor_pos, right_motor_pos, heading_rad,
    // new_x, new_y, new_heading_rad (32 bits each, lowest first)
    input  logic [255:0]                    s_tdata,
    // func
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pose_x, pose_y, orientation_deg (32 bits each, lowest first)
    output logic [95:0]                     m_tdata
);

    localparam int NUM_W    = 33 + FRAC_BITS;
    localparam int ANG_W    = 64 - FRAC_BITS;
    localparam int HALF_SH  = 29 - FRAC_BITS;
    localparam int HEAD_SH  = 30 - FRAC_BITS;
    localparam int VW       = tw_odo_pkg::VEC_W;
    localparam int OW       = tw_odo_pkg::CFG_W;

    tw_odo_pkg::seq_state_t state_reg, state_next;
    logic [1:0]              mode_reg, mode_next;
    logic signed [OW-1:0]    fwd_off_reg, fwd_off_next;
    logic signed [OW-1:0]    side_off_reg, side_off_next;
    logic signed [31:0]      last_fwd_reg, last_fwd_next;
    logic signed [31:0]      last_side_reg, last_side_next;
    logic signed [31:0]      last_head_reg, last_head_next;
    logic signed [31:0]      acc_x_reg, acc_x_next;
    logic signed [31:0]      acc_y_reg, acc_y_next;
    logic signed [31:0]      acc_deg_reg, acc_deg_next;
    logic                    issued_reg, issued_next;
    logic                    m_valid_reg, m_valid_next;

    tw_odo_pkg::func_t       func_reg, func_next;
    logic signed [31:0]      cf_reg, cf_next;
    logic signed [31:0]      cs_reg, cs_next;
    logic signed [31:0]      head_reg, head_next;
    logic signed [31:0]      nx_reg, nx_next;
    logic signed [31:0]      ny_reg, ny_next;
    logic signed [31:0]      nh_reg, nh_next;
    logic signed [32:0]      fd_reg, fd_next;
    logic signed [32:0]      sd_reg, sd_next;
    logic signed [32:0]      dh_reg, dh_next;
    logic signed [33:0]      len_reg, len_next;
    logic signed [NUM_W-1:0] quot_reg, quot_next;
    logic signed [31:0]      lx_reg, lx_next;
    logic signed [31:0]      ly_reg, ly_next;
    logic [95:0]             m_data_reg, m_data_next;

    logic                    s_accept;
    logic signed [31:0]      in_fwd, in_side, in_left, in_right;
    logic signed [32:0]      motor_sum;
    logic signed [32:0]      fd_w, sd_w, dh_w;
    logic signed [ANG_W-1:0] half_ang;
    logic signed [ANG_W-1:0] rot2_ang;
    logic signed [31:0]      deg_src;
    logic signed [63:0]      dprod;

    logic                    rot_start, rot_done;
    logic signed [32:0]      rot_x_in, rot_y_in;
    logic signed [ANG_W-1:0] rot_ang_in;
    logic signed [VW-1:0]    rot_x, rot_y;

    tw_odo_pkg::md_req_t     md_req;
    logic                    md_done;
    logic signed [NUM_W-1:0] md_num;
    logic signed [NUM_W:0]   md_a;
    logic signed [NUM_W-1:0] md_quot;
    logic signed [31:0]      md_prod;

    assign s_tready = (state_reg == tw_odo_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign in_fwd    = s_tdata[31:0];
    assign in_side   = s_tdata[63:32];
    assign in_left   = s_tdata[95:64];
    assign in_right  = s_tdata[127:96];
    assign motor_sum = 33'(in_left) + 33'(in_right);

    assign fd_w = 33'(cf_reg) - 33'(last_fwd_reg);
    assign sd_w = 33'(cs_reg) - 33'(last_side_reg);
    assign dh_w = 33'(head_reg) - 33'(last_head_reg);

    assign half_ang = ANG_W'(dh_reg) <<< HALF_SH;
    assign rot2_ang = -((ANG_W'(last_head_reg) <<< HEAD_SH) + half_ang);

    assign deg_src = (func_reg == tw_odo_pkg::FUNC_SET) ? nh_reg : head_reg;
    assign dprod   = deg_src * $signed({1'b0, tw_odo_pkg::Q24_RAD2DEG});

    assign rot_start  = !issued_reg &&
                        (state_reg == tw_odo_pkg::ST_ROT1 || state_reg == tw_odo_pkg::ST_ROT2);
    assign rot_x_in   = (state_reg == tw_odo_pkg::ST_ROT1) ? 33'(tw_odo_pkg::Q30_ONE)
                                                           : 33'(lx_reg);
    assign rot_y_in   = (state_reg == tw_odo_pkg::ST_ROT1) ? '0 : 33'(ly_reg);
    assign rot_ang_in = (state_reg == tw_odo_pkg::ST_ROT1) ? half_ang : rot2_ang;

    assign md_req.start = !issued_reg &&
                          (state_reg == tw_odo_pkg::ST_DIVS || state_reg == tw_odo_pkg::ST_MULS ||
                           state_reg == tw_odo_pkg::ST_DIVF || state_reg == tw_odo_pkg::ST_MULF);
    assign md_req.op    = (state_reg == tw_odo_pkg::ST_MULS || state_reg == tw_odo_pkg::ST_MULF) ?
                          tw_odo_pkg::MD_OP_MUL : tw_odo_pkg::MD_OP_DIV;
    assign md_num       = (state_reg == tw_odo_pkg::ST_DIVF) ? (NUM_W'(fd_reg) <<< FRAC_BITS)
                                                             : (NUM_W'(sd_reg) <<< FRAC_BITS);
    assign md_a         = (NUM_W+1)'(quot_reg) +
                          ((state_reg == tw_odo_pkg::ST_MULF) ? (NUM_W+1)'(fwd_off_reg)
                                                              : (NUM_W+1)'(side_off_reg));

    tw_odo_rotator #(
        .ANG_W        (ANG_W),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_rot (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rot_start),
        .x_in     (rot_x_in),
        .y_in     (rot_y_in),
        .angle_in (rot_ang_in),
        .done     (rot_done),
        .x_out    (rot_x),
        .y_out    (rot_y)
    );

    tw_odo_muldiv #(
        .NUM_W (NUM_W)
    ) u_md (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (md_req),
        .num_in   (md_num),
        .den_in   (dh_reg),
        .a_in     (md_a),
        .b_in     (len_reg),
        .done     (md_done),
        .quot_out (md_quot),
        .prod_out (md_prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tw_odo_pkg::ST_IDLE;
            mode_reg      <= tw_odo_pkg::MODE_TWO;
            fwd_off_reg   <= '0;
            side_off_reg  <= '0;
            last_fwd_reg  <= '0;
            last_side_reg <= '0;
            last_head_reg <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            acc_deg_reg   <= '0;
            issued_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            fwd_off_reg   <= fwd_off_next;
            side_off_reg  <= side_off_next;
            last_fwd_reg  <= last_fwd_next;
            last_side_reg <= last_side_next;
            last_head_reg <= last_head_next;
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
            acc_deg_reg   <= acc_deg_next;
            issued_reg    <= issued_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        cf_reg     <= cf_next;
        cs_reg     <= cs_next;
        head_reg   <= head_next;
        nx_reg     <= nx_next;
        ny_reg     <= ny_next;
        nh_reg     <= nh_next;
        fd_reg     <= fd_next;
        sd_reg     <= sd_next;
        dh_reg     <= dh_next;
        len_reg    <= len_next;
        quot_reg   <= quot_next;
        lx_reg     <= lx_next;
        ly_reg     <= ly_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        fwd_off_next   = fwd_off_reg;
        side_off_next  = side_off_reg;
        last_fwd_next  = last_fwd_reg;
        last_side_next = last_side_reg;
        last_head_next = last_head_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        acc_deg_next   = acc_deg_reg;
        issued_next    = issued_reg;
        m_valid_next   = m_valid_reg;
        func_next      = func_reg;
        cf_next        = cf_reg;
        cs_next        = cs_reg;
        head_next      = head_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        nh_next        = nh_reg;
        fd_next        = fd_reg;
        sd_next        = sd_reg;
        dh_next        = dh_reg;
        len_next       = len_reg;
        quot_next      = quot_reg;
        lx_next        = lx_reg;
        ly_next        = ly_reg;
        m_data_next    = m_data_reg;

        if (cfg_we) begin
            case (cfg_addr)
                tw_odo_pkg::REG_TRACKER_MODE: mode_next     = cfg_wdata[1:0];
                tw_odo_pkg::REG_FWD_OFFSET:   fwd_off_next  = cfg_wdata;
                tw_odo_pkg::REG_SIDE_OFFSET:  side_off_next = cfg_wdata;
                default: ;
            endcase
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (rot_start || md_req.start) begin
            issued_next = 1'b1;
        end else if (rot_done || md_done) begin
            issued_next = 1'b0;
        end

        case (state_reg)
            tw_odo_pkg::ST_IDLE: begin
                if (s_accept) begin
                    func_next = tw_odo_pkg::func_t'(s_tuser);
                    head_next = s_tdata[159:128];
                    nx_next   = s_tdata[191:160];
                    ny_next   = s_tdata[223:192];
                    nh_next   = s_tdata[255:224];
                    case (mode_reg)
                        tw_odo_pkg::MODE_MOTORS: begin
                            cf_next = 32'(motor_sum >>> 1);
                            cs_next = '0;
                        end
                        tw_odo_pkg::MODE_FORWARD: begin
                            cf_next = in_fwd;
                            cs_next = '0;
                        end
                        tw_odo_pkg::MODE_SIDE_RIGHT: begin
                            cf_next = in_right;
                            cs_next = in_side;
                        end
                        default: begin
                            cf_next = in_fwd;
                            cs_next = in_side;
                        end
                    endcase
                    state_next = tw_odo_pkg::ST_PREP;
                end
            end
            tw_odo_pkg::ST_PREP: begin
                case (func_reg)
                    tw_odo_pkg::FUNC_UPDATE: begin
                        fd_next = fd_w;
                        sd_next = sd_w;
                        dh_next = dh_w;
                        if (dh_w == '0) begin
                            lx_next    = tw_odo_pkg::sat32(64'(sd_w));
                            ly_next    = tw_odo_pkg::sat32(64'(fd_w));
                            state_next = tw_odo_pkg::ST_ROT2;
                        end else begin
                            state_next = tw_odo_pkg::ST_ROT1;
                        end
                    end
                    tw_odo_pkg::FUNC_START: begin
                        last_fwd_next  = '0;
                        last_side_next = '0;
                        last_head_next = head_reg;
                        state_next     = tw_odo_pkg::ST_OUT;
                    end
                    tw_odo_pkg::FUNC_SET: begin
                        acc_x_next = nx_reg;
                        acc_y_next = ny_reg;
                        state_next = tw_odo_pkg::ST_DEG;
                    end
                    default: begin
                        state_next = tw_odo_pkg::ST_OUT;
                    end
                endcase
            end
            tw_odo_pkg::ST_ROT1: begin
                if (rot_done) begin
                    len_next   = $signed({rot_y[32:0], 1'b0});
                    state_next = tw_odo_pkg::ST_DIVS;
                end
            end
            tw_odo_pkg::ST_DIVS: begin
                if (md_done) begin
                    quot_next  = md_quot;
                    state_next = tw_odo_pkg::ST_MULS;
                end
            end
            tw_odo_pkg::ST_MULS: begin
                if (md_done) begin
                    lx_next    = md_prod;
                    state_next = tw_odo_pkg::ST_DIVF;
                end
            end
            tw_odo_pkg::ST_DIVF: begin
                if (md_done) begin
                    quot_next  = md_quot;
                    state_next = tw_odo_pkg::ST_MULF;
                end
            end
            tw_odo_pkg::ST_MULF: begin
                if (md_done) begin
                    ly_next    = md_prod;
                    state_next = tw_odo_pkg::ST_ROT2;
                end
            end
            tw_odo_pkg::ST_ROT2: begin
                if (rot_done) begin
                    acc_x_next = tw_odo_pkg::sat32(64'(acc_x_reg) + 64'(rot_x));
                    acc_y_next = tw_odo_pkg::sat32(64'(acc_y_reg) + 64'(rot_y));
                    state_next = tw_odo_pkg::ST_DEG;
                end
            end
            tw_odo_pkg::ST_DEG: begin
                acc_deg_next   = tw_odo_pkg::sat32(dprod >>> 24);
                last_head_next = deg_src;
                if (func_reg == tw_odo_pkg::FUNC_UPDATE) begin
                    last_fwd_next  = cf_reg;
                    last_side_next = cs_reg;
                end
                state_next = tw_odo_pkg::ST_OUT;
            end
            tw_odo_pkg::ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_next  = {acc_deg_reg, acc_y_reg, acc_x_reg};
                    m_valid_next = 1'b1;
                    state_next   = tw_odo_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tw_odo_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/tw_odo_checker.sv -----
// Port-level checker for the odometry block, attached to the top level by bind.
// Depends only on the top-level ports.
module tw_odo_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [95:0]  m_tdata
);

    logic [1:0] pend_reg, pend_next;
    logic       s_beat, m_beat;

    assign s_beat = s_tvalid && s_tready;
    assign m_beat = m_tvalid && m_tready;

    always_comb begin
        pend_next = pend_reg;
        if (s_beat && !m_beat) begin
            pend_next = pend_reg + 2'd1;
        end else if (!s_beat && m_beat) begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    a_result_has_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 2'd0)
        else $error("result beat without an input beat");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat |=> !s_tready)
        else $error("input ready right after an accepted beat");

    a_one_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> pend_reg != 2'd2)
        else $error("input ready with two items pending");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

endmodule

bind tracking_wheel_odometry_update tw_odo_checker u_tw_odo_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
